/* rtl/tdv_pkg.sv */
// ----------------------------------------------------------------------------
// tdv_pkg
// Shared codes, constants and controller/datapath interface types for the
// three-oscillator voice.
// ----------------------------------------------------------------------------
package tdv_pkg;

    localparam int NUM_OSC = 3;
    localparam int OSC_IW  = 2;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 48;

    localparam logic [1:0] FUNC_TICK     = 2'd0;
    localparam logic [1:0] FUNC_NOTE_ON  = 2'd1;
    localparam logic [1:0] FUNC_NOTE_OFF = 2'd2;

    localparam logic [1:0] WAVE_SINE   = 2'd0;
    localparam logic [1:0] WAVE_SAW    = 2'd1;
    localparam logic [1:0] WAVE_SQUARE = 2'd2;

    localparam logic [2:0] STAGE_IDLE    = 3'd0;
    localparam logic [2:0] STAGE_ATTACK  = 3'd1;
    localparam logic [2:0] STAGE_DECAY   = 3'd2;
    localparam logic [2:0] STAGE_SUSTAIN = 3'd3;
    localparam logic [2:0] STAGE_RELEASE = 3'd4;

    localparam logic [CFG_IW-1:0] CFG_WAVE_MODE     = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_ENV_ENABLE    = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_ATTACK_STEP   = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_DECAY_STEP    = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_RELEASE_STEP  = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_SUSTAIN_LEVEL = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_OSC_GAINS     = 3'd6;

    localparam logic [15:0] RST_ATTACK_STEP   = 16'd4095;
    localparam logic [15:0] RST_DECAY_STEP    = 16'd33;
    localparam logic [15:0] RST_RELEASE_STEP  = 16'd65;
    localparam logic [15:0] RST_SUSTAIN_LEVEL = 16'd16352;
    localparam logic [47:0] RST_OSC_GAINS     = 48'hFFFF_FFFF_FFFF;

    localparam int SINE_DEPTH     = 4096;
    localparam int SINE_AW        = $clog2(SINE_DEPTH);
    localparam int SINE_ARG_BITS  = 17;

    localparam int          ENV_MAX   = 65535;
    localparam logic [16:0] ENV_MAX_W = 17'(ENV_MAX);
    localparam logic [15:0] ENV_FULL  = 16'hFFFF;

    localparam logic [15:0] POLY_K0    = 16'd153;
    localparam logic [15:0] POLY_C1    = 16'd2611;
    localparam logic [15:0] POLY_C2    = 16'd21167;
    localparam logic [15:0] POLY_C3    = 16'd51472;
    localparam logic [15:0] SINE_AMP   = 16'd2047;
    localparam logic [31:0] SINE_ROUND = 32'd16384;
    localparam logic [11:0] SINE_MID   = 12'd2048;
    localparam logic [15:0] HALF_TURN  = 16'h8000;

    localparam logic [11:0] SQUARE_BIT  = 12'h800;
    localparam logic [11:0] SQUARE_FLIP = 12'h100;
    localparam logic [7:0]  DAC_CMD     = 8'h30;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_R_R,
        MUL_K_X2,
        MUL_T_X2,
        MUL_R_T,
        MUL_S_AMP,
        MUL_SHAPE_GAIN,
        MUL_ENV_MIX
    } tdv_mul_op_t;

    typedef enum logic [2:0] {
        WB_NONE,
        WB_X2,
        WB_T1,
        WB_T2,
        WB_T3,
        WB_S,
        WB_V,
        WB_MIX
    } tdv_wb_op_t;

    typedef struct packed {
        logic        accept;
        logic        advance;
        logic        load_phase;
        logic        env_step;
        logic        out_load;
        tdv_mul_op_t mul_op;
        tdv_wb_op_t  wb_op;
    } tdv_cmd_t;

    typedef struct packed {
        logic tick_item;
        logic sine_mode;
        logic last_osc;
        logic out_free;
    } tdv_status_t;

endpackage

/* rtl/three_osc_dds_adsr_voice_unit.sv */
// ----------------------------------------------------------------------------
// three_osc_dds_adsr_voice_unit
// One synthesizer voice: three phase-accumulator oscillators, waveform
// shaping, gain mixing and an ADSR amplitude envelope, with DAC bytes out.
// ----------------------------------------------------------------------------
// Note-on and note-off beats are taken in the idle state, do not stall the
// input and give no result. A tick beat gives one sample; its length is set
// by the single shared 16x16 multiplier, which every product goes through
// with a register after it. With the sine waveform each oscillator runs a
// polynomial evaluation (square, three polynomial terms, sine product and
// amplitude scaling) before its gain product; with sawtooth, square or the
// unused mode it goes straight to the gain product. The input stays stalled
// for the whole of a tick. A finished sample is held in the output register
// while the next beat is accepted; when a new sample is ready before the
// previous one has been taken, the tick waits and the input stays stalled
// until the output register frees up.
module three_osc_dds_adsr_voice_unit
    import tdv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        func,
    input  logic [6:0]        note,
    input  logic [6:0]        velocity,
    input  logic              use_velocity,
    input  logic [15:0]       phase_step_a,
    input  logic [15:0]       phase_step_b,
    input  logic [15:0]       phase_step_c,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [15:0]       sample_value,
    output logic [7:0]        dac_first_byte,
    output logic [7:0]        dac_second_byte,
    output logic [2:0]        stage_now
);

    tdv_cmd_t    cmd;
    tdv_status_t status;

    tdv_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tdv_datapath u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .func            (func),
        .note            (note),
        .velocity        (velocity),
        .use_velocity    (use_velocity),
        .phase_step_a    (phase_step_a),
        .phase_step_b    (phase_step_b),
        .phase_step_c    (phase_step_c),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .sample_value    (sample_value),
        .dac_first_byte  (dac_first_byte),
        .dac_second_byte (dac_second_byte),
        .stage_now       (stage_now),
        .cmd             (cmd),
        .status          (status)
    );

endmodule

/* rtl/tdv_ctrl.sv */
// ----------------------------------------------------------------------------
// tdv_ctrl
// Sequencer for the voice: takes input beats and steps the datapath through
// the oscillator, mixer and envelope micro-operations of a tick.
// ----------------------------------------------------------------------------
module tdv_ctrl
    import tdv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  tdv_status_t status,
    output tdv_cmd_t    cmd
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_ADV   = 5'd1;
    localparam logic [4:0] ST_PHASE = 5'd2;
    localparam logic [4:0] ST_X2M   = 5'd3;
    localparam logic [4:0] ST_X2W   = 5'd4;
    localparam logic [4:0] ST_T1M   = 5'd5;
    localparam logic [4:0] ST_T1W   = 5'd6;
    localparam logic [4:0] ST_T2M   = 5'd7;
    localparam logic [4:0] ST_T2W   = 5'd8;
    localparam logic [4:0] ST_T3M   = 5'd9;
    localparam logic [4:0] ST_T3W   = 5'd10;
    localparam logic [4:0] ST_SM    = 5'd11;
    localparam logic [4:0] ST_SW    = 5'd12;
    localparam logic [4:0] ST_VM    = 5'd13;
    localparam logic [4:0] ST_VW    = 5'd14;
    localparam logic [4:0] ST_GM    = 5'd15;
    localparam logic [4:0] ST_GW    = 5'd16;
    localparam logic [4:0] ST_ENV   = 5'd17;
    localparam logic [4:0] ST_EM    = 5'd18;
    localparam logic [4:0] ST_EW    = 5'd19;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_op = MUL_NONE;
        cmd.wb_op  = WB_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && status.tick_item)
                begin
                    state_next = ST_ADV;
                end
            end
            ST_ADV:
            begin
                cmd.advance = 1'b1;
                state_next  = ST_PHASE;
            end
            ST_PHASE:
            begin
                cmd.load_phase = 1'b1;
                state_next     = status.sine_mode ? ST_X2M : ST_GM;
            end
            ST_X2M:
            begin
                cmd.mul_op = MUL_R_R;
                state_next = ST_X2W;
            end
            ST_X2W:
            begin
                cmd.wb_op  = WB_X2;
                state_next = ST_T1M;
            end
            ST_T1M:
            begin
                cmd.mul_op = MUL_K_X2;
                state_next = ST_T1W;
            end
            ST_T1W:
            begin
                cmd.wb_op  = WB_T1;
                state_next = ST_T2M;
            end
            ST_T2M:
            begin
                cmd.mul_op = MUL_T_X2;
                state_next = ST_T2W;
            end
            ST_T2W:
            begin
                cmd.wb_op  = WB_T2;
                state_next = ST_T3M;
            end
            ST_T3M:
            begin
                cmd.mul_op = MUL_T_X2;
                state_next = ST_T3W;
            end
            ST_T3W:
            begin
                cmd.wb_op  = WB_T3;
                state_next = ST_SM;
            end
            ST_SM:
            begin
                cmd.mul_op = MUL_R_T;
                state_next = ST_SW;
            end
            ST_SW:
            begin
                cmd.wb_op  = WB_S;
                state_next = ST_VM;
            end
            ST_VM:
            begin
                cmd.mul_op = MUL_S_AMP;
                state_next = ST_VW;
            end
            ST_VW:
            begin
                cmd.wb_op  = WB_V;
                state_next = ST_GM;
            end
            ST_GM:
            begin
                cmd.mul_op = MUL_SHAPE_GAIN;
                state_next = ST_GW;
            end
            ST_GW:
            begin
                cmd.wb_op  = WB_MIX;
                state_next = status.last_osc ? ST_ENV : ST_PHASE;
            end
            ST_ENV:
            begin
                cmd.env_step = 1'b1;
                state_next   = ST_EM;
            end
            ST_EM:
            begin
                cmd.mul_op = MUL_ENV_MIX;
                state_next = ST_EW;
            end
            ST_EW:
            begin
                cmd.out_load = status.out_free;
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/tdv_datapath.sv */
// ----------------------------------------------------------------------------
// tdv_datapath
// Configuration registers, phase accumulators, a shared 16x16 multiplier with
// its operand and writeback registers, the envelope and the output register.
// ----------------------------------------------------------------------------
module tdv_datapath
    import tdv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    input  logic [1:0]        func,
    input  logic [6:0]        note,
    input  logic [6:0]        velocity,
    input  logic              use_velocity,
    input  logic [15:0]       phase_step_a,
    input  logic [15:0]       phase_step_b,
    input  logic [15:0]       phase_step_c,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [15:0]       sample_value,
    output logic [7:0]        dac_first_byte,
    output logic [7:0]        dac_second_byte,
    output logic [2:0]        stage_now,
    input  tdv_cmd_t          cmd,
    output tdv_status_t       status
);

    logic [1:0]  wave_mode_reg;
    logic        env_enable_reg;
    logic [15:0] attack_step_reg;
    logic [15:0] decay_step_reg;
    logic [15:0] release_step_reg;
    logic [15:0] sustain_level_reg;
    logic [47:0] osc_gains_reg;

    logic [15:0] phase_accum_reg [NUM_OSC];
    logic [15:0] phase_incr_reg [NUM_OSC];
    logic [15:0] env_level_reg;
    logic [2:0]  env_stage_reg;
    logic [6:0]  last_note_reg;
    logic [15:0] sustain_target_reg;
    logic [OSC_IW-1:0] osc_idx_reg;
    logic        out_valid_reg;

    logic [15:0] r_reg;
    logic [1:0]  quad_reg;
    logic [15:0] x2_reg;
    logic [15:0] t_reg;
    logic [15:0] s_reg;
    logic [11:0] shape_reg;
    logic [31:0] prod_reg;
    logic [31:0] mix_reg;
    logic [15:0] sample_reg;
    logic [2:0]  stage_out_reg;

    logic [15:0] env_level_next;
    logic [2:0]  env_stage_next;
    logic        env_clear_accum;

    logic [11:0] phase12;
    logic [SINE_AW-1:0] sine_entry;
    logic [SINE_ARG_BITS-1:0] sine_arg;
    logic [15:0] r_base;
    logic [11:0] shape_direct;
    logic [15:0] gain_sel;
    logic [15:0] mul_a;
    logic [15:0] mul_b;
    logic [31:0] v_sum;
    logic [16:0] v_raw;
    logic [10:0] v_clip;
    logic [15:0] vel_target;
    logic [16:0] env_sum;
    logic [16:0] env_diff_decay;
    logic [16:0] env_diff_release;
    logic [15:0] out_sample;

    assign status.tick_item = (func == FUNC_TICK);
    assign status.sine_mode = (wave_mode_reg == WAVE_SINE);
    assign status.last_osc  = (osc_idx_reg == OSC_IW'(NUM_OSC - 1));
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign phase12    = phase_accum_reg[osc_idx_reg][15:4];
    assign sine_entry = phase12[11 -: SINE_AW];
    assign sine_arg   = {sine_entry, {(SINE_ARG_BITS - SINE_AW){1'b0}}};
    assign r_base     = {1'b0, sine_arg[14:0]};

    always_comb
    begin
        case (wave_mode_reg)
            WAVE_SAW:    shape_direct = phase12;
            WAVE_SQUARE: shape_direct = (phase12 & SQUARE_BIT) ^ SQUARE_FLIP;
            default:     shape_direct = 12'd0;
        endcase
    end

    always_comb
    begin
        case (osc_idx_reg)
            2'd0:    gain_sel = osc_gains_reg[15:0];
            2'd1:    gain_sel = osc_gains_reg[31:16];
            default: gain_sel = osc_gains_reg[47:32];
        endcase
    end

    always_comb
    begin
        mul_a = 16'd0;
        mul_b = 16'd0;
        case (cmd.mul_op)
            MUL_R_R:
            begin
                mul_a = r_reg;
                mul_b = r_reg;
            end
            MUL_K_X2:
            begin
                mul_a = POLY_K0;
                mul_b = x2_reg;
            end
            MUL_T_X2:
            begin
                mul_a = t_reg;
                mul_b = x2_reg;
            end
            MUL_R_T:
            begin
                mul_a = r_reg;
                mul_b = t_reg;
            end
            MUL_S_AMP:
            begin
                mul_a = s_reg;
                mul_b = SINE_AMP;
            end
            MUL_SHAPE_GAIN:
            begin
                mul_a = {4'd0, shape_reg};
                mul_b = gain_sel;
            end
            MUL_ENV_MIX:
            begin
                mul_a = env_level_reg;
                mul_b = mix_reg[31:16];
            end
            default:
            begin
                mul_a = 16'd0;
                mul_b = 16'd0;
            end
        endcase
    end

    assign v_sum  = prod_reg + SINE_ROUND;
    assign v_raw  = v_sum[31:15];
    assign v_clip = (v_raw > 17'(SINE_AMP)) ? SINE_AMP[10:0] : v_raw[10:0];

    assign vel_target = {9'd0, velocity} * {7'd0, sustain_level_reg[15:7]};

    assign env_sum          = {1'b0, env_level_reg} + {1'b0, attack_step_reg};
    assign env_diff_decay   = {1'b0, env_level_reg} - {1'b0, decay_step_reg};
    assign env_diff_release = {1'b0, env_level_reg} - {1'b0, release_step_reg};

    always_comb
    begin
        env_level_next  = env_level_reg;
        env_stage_next  = env_stage_reg;
        env_clear_accum = 1'b0;
        if (!env_enable_reg)
        begin
            env_level_next = ENV_FULL;
        end
        else
        begin
            case (env_stage_reg)
                STAGE_ATTACK:
                begin
                    if (env_sum > ENV_MAX_W)
                    begin
                        env_level_next = ENV_MAX_W[15:0];
                        env_stage_next = STAGE_DECAY;
                    end
                    else
                    begin
                        env_level_next = env_sum[15:0];
                    end
                end
                STAGE_DECAY:
                begin
                    if (env_diff_decay[16] || (env_diff_decay[15:0] < sustain_target_reg)
                        || (env_diff_decay > ENV_MAX_W))
                    begin
                        env_level_next = sustain_target_reg;
                        env_stage_next = STAGE_SUSTAIN;
                    end
                    else
                    begin
                        env_level_next = env_diff_decay[15:0];
                    end
                end
                STAGE_SUSTAIN:
                begin
                    env_level_next = sustain_target_reg;
                end
                STAGE_RELEASE:
                begin
                    if (env_diff_release[16] || (env_diff_release > ENV_MAX_W))
                    begin
                        env_level_next = 16'd0;
                        env_stage_next = STAGE_IDLE;
                    end
                    else
                    begin
                        env_level_next = env_diff_release[15:0];
                    end
                end
                default:
                begin
                    env_level_next  = 16'd0;
                    env_clear_accum = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_mode_reg     <= WAVE_SINE;
            env_enable_reg    <= 1'b0;
            attack_step_reg   <= RST_ATTACK_STEP;
            decay_step_reg    <= RST_DECAY_STEP;
            release_step_reg  <= RST_RELEASE_STEP;
            sustain_level_reg <= RST_SUSTAIN_LEVEL;
            osc_gains_reg     <= RST_OSC_GAINS;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_WAVE_MODE:     wave_mode_reg     <= cfg_data[1:0];
                CFG_ENV_ENABLE:    env_enable_reg    <= cfg_data[0];
                CFG_ATTACK_STEP:   attack_step_reg   <= cfg_data[15:0];
                CFG_DECAY_STEP:    decay_step_reg    <= cfg_data[15:0];
                CFG_RELEASE_STEP:  release_step_reg  <= cfg_data[15:0];
                CFG_SUSTAIN_LEVEL: sustain_level_reg <= cfg_data[15:0];
                CFG_OSC_GAINS:     osc_gains_reg     <= cfg_data[47:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_OSC; i++)
            begin
                phase_accum_reg[i] <= 16'd0;
                phase_incr_reg[i]  <= 16'd0;
            end
            env_level_reg      <= 16'd0;
            env_stage_reg      <= STAGE_IDLE;
            last_note_reg      <= 7'd0;
            sustain_target_reg <= 16'd0;
            osc_idx_reg        <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                if (func == FUNC_NOTE_ON)
                begin
                    phase_incr_reg[0]  <= phase_step_a;
                    phase_incr_reg[1]  <= phase_step_b;
                    phase_incr_reg[2]  <= phase_step_c;
                    last_note_reg      <= note;
                    sustain_target_reg <= use_velocity ? vel_target : sustain_level_reg;
                    env_stage_reg      <= STAGE_ATTACK;
                end
                else if ((func == FUNC_NOTE_OFF) && (note == last_note_reg))
                begin
                    env_stage_reg <= STAGE_RELEASE;
                end
            end
            if (cmd.advance)
            begin
                for (int i = 0; i < NUM_OSC; i++)
                begin
                    phase_accum_reg[i] <= phase_accum_reg[i] + phase_incr_reg[i];
                end
                osc_idx_reg <= '0;
            end
            if (cmd.wb_op == WB_MIX)
            begin
                osc_idx_reg <= osc_idx_reg + OSC_IW'(1);
            end
            if (cmd.env_step)
            begin
                env_level_reg <= env_level_next;
                env_stage_reg <= env_stage_next;
                if (env_clear_accum)
                begin
                    for (int i = 0; i < NUM_OSC; i++)
                    begin
                        phase_accum_reg[i] <= 16'd0;
                    end
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.advance)
        begin
            mix_reg <= 32'd0;
        end
        if (cmd.load_phase)
        begin
            quad_reg  <= sine_arg[16:15];
            r_reg     <= sine_arg[15] ? (HALF_TURN - r_base) : r_base;
            shape_reg <= shape_direct;
        end
        if (cmd.mul_op != MUL_NONE)
        begin
            prod_reg <= mul_a * mul_b;
        end
        case (cmd.wb_op)
            WB_X2:  x2_reg    <= prod_reg[30:15];
            WB_T1:  t_reg     <= POLY_C1 - prod_reg[30:15];
            WB_T2:  t_reg     <= POLY_C2 - prod_reg[30:15];
            WB_T3:  t_reg     <= POLY_C3 - prod_reg[30:15];
            WB_S:   s_reg     <= prod_reg[30:15];
            WB_V:   shape_reg <= quad_reg[1] ? (SINE_MID - {1'b0, v_clip})
                                             : (SINE_MID + {1'b0, v_clip});
            WB_MIX: mix_reg   <= mix_reg + {prod_reg[29:0], 2'b00};
            default: ;
        endcase
        if (cmd.out_load)
        begin
            sample_reg    <= out_sample;
            stage_out_reg <= env_stage_reg;
        end
    end

    assign out_sample = prod_reg[31:16];

    assign out_valid       = out_valid_reg;
    assign sample_value    = sample_reg;
    assign dac_first_byte  = DAC_CMD | {4'd0, sample_reg[15:12]};
    assign dac_second_byte = sample_reg[11:4];
    assign stage_now       = stage_out_reg;

endmodule
